// ----- rtl/core/keyed_six_bit_packer_codec_assert.svh -----
// assertion macros for the keyed six-bit packer codec
`ifndef KEYED_SIX_BIT_PACKER_CODEC_ASSERT_SVH
`define KEYED_SIX_BIT_PACKER_CODEC_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KSB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define KSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ksbpc_pkg.sv -----
// shared types, codes and offset functions of the keyed six-bit packer codec
package ksbpc_pkg;

    localparam int KEY_MAX   = 8;
    localparam int MAX_RES   = 2;
    localparam int RES_DEPTH = 4;
    localparam int RES_CNT_W = 3;

    localparam logic [1:0] CFG_KEY_MODE   = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH = 2'd1;
    localparam logic [1:0] CFG_KEY_CHARS  = 2'd2;

    localparam logic [1:0] KEY_NONE = 2'd0;
    localparam logic [1:0] KEY_ADD  = 2'd1;
    localparam logic [1:0] KEY_SUB  = 2'd2;

    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    typedef struct packed {
        logic [7:0] data_out;
        logic       run_end;
        logic       message_end;
    } t_res;

    function automatic logic [5:0] offset_enc(logic [1:0] mode, logic [5:0] v, logic [5:0] k);
        logic [5:0] r;
        unique case (mode)
            KEY_ADD: r = v + k;
            KEY_SUB: r = v - k;
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] offset_dec(logic [1:0] mode, logic [5:0] v, logic [5:0] k);
        logic [5:0] r;
        unique case (mode)
            KEY_ADD: r = v - k;
            KEY_SUB: r = v + k;
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/keyed_six_bit_packer_codec.sv -----
// keyed six-bit packer codec: top level with datapath and result buffer
//
// Input words arrive on the s_axis channel: tdata carries a byte to encode or a
// symbol index to decode, tuser selects encode (0) or decode (1), tlast marks the
// last word of a message and flushes nonzero leftover bits. Results leave on the
// m_axis channel: tdata is a symbol index or a decoded byte, tuser flags the last
// result of its input word, tlast the last result of a message.
// Each input word is worked in the cycle it is accepted; its zero, one or two
// results go into a four-entry buffer, and if no older one waits the first
// shows on m_axis in the next cycle. The buffer drains one result per cycle
// while the receiver is ready, so words with one result sustain one word per
// cycle; two-result words (every third encode byte or a flush) fill the buffer.
// s_axis_tready is high while the buffer holds at most two results, so a new word
// is taken while earlier results still wait; a stalled receiver fills the buffer
// and then holds off the sender.
// The user writes key registers via the cfg port only while idle; not enforced.
// Reset (synchronous, active low) empties the buffer, zeroes the packer state and
// loads key mode none, key length one and an all-zero key.
module keyed_six_bit_packer_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // data_in
    input  logic        s_axis_tuser,  // func
    input  logic        s_axis_tlast,  // final_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // data_out
    output logic        m_axis_tuser,  // run_end
    output logic        m_axis_tlast   // message_end
);
    import ksbpc_pkg::*;

    logic [1:0]  r_key_mode;
    logic [3:0]  r_key_length;
    logic [63:0] r_key_chars;

    logic [5:0] r_pend, n_pend;
    logic [1:0] r_gp, n_gp;
    logic [2:0] r_kp, n_kp;

    t_res                 r_buf [RES_DEPTH];
    t_res                 n_buf [RES_DEPTH];
    logic [RES_CNT_W-1:0] r_cnt, n_cnt;

    logic       push, pop;
    logic [3:0] eff_len;
    logic [3:0] kp_inc0, kp_inc1;
    logic [2:0] kp1, kp2;
    logic [5:0] k0, k1;
    logic [1:0] pe;
    logic [11:0] enc_dw, dec_dw;
    logic [5:0] dec_s;
    logic [7:0] val0, val1;
    logic [1:0] n_res;
    logic [RES_CNT_W-1:0] base;
    logic [1:0] wr_idx;

    assign push = s_axis_tvalid & s_axis_tready;
    assign pop  = m_axis_tvalid & m_axis_tready;

    assign s_axis_tready = (r_cnt <= RES_CNT_W'(RES_DEPTH - MAX_RES));
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_buf[0].data_out;
    assign m_axis_tuser  = r_buf[0].run_end;
    assign m_axis_tlast  = r_buf[0].message_end;

    // key position walk and key characters
    always_comb begin
        if (r_key_length == 4'd0) begin
            eff_len = 4'd1;
        end else if (r_key_length > 4'(KEY_MAX)) begin
            eff_len = 4'(KEY_MAX);
        end else begin
            eff_len = r_key_length;
        end
        kp_inc0 = {1'b0, r_kp} + 4'd1;
        kp1     = (kp_inc0 >= eff_len) ? 3'd0 : kp_inc0[2:0];
        kp_inc1 = {1'b0, kp1} + 4'd1;
        kp2     = (kp_inc1 >= eff_len) ? 3'd0 : kp_inc1[2:0];
        k0      = r_key_chars[{r_kp, 3'b000} +: 6];
        k1      = r_key_chars[{kp1, 3'b000} +: 6];
    end

    // packing datapath
    always_comb begin
        pe     = (r_gp == 2'd3) ? 2'd0 : r_gp;
        enc_dw = {6'b0, r_pend} | ({4'b0, s_axis_tdata} << {pe, 1'b0});
        dec_s  = offset_dec(r_key_mode, s_axis_tdata[5:0], k0);
        dec_dw = {6'b0, r_pend} | ({6'b0, dec_s} << (4'd8 - {1'b0, r_gp, 1'b0}));

        val0   = '0;
        val1   = '0;
        n_res  = 2'd0;
        n_pend = r_pend;
        n_gp   = r_gp;
        n_kp   = kp1;

        if (s_axis_tuser == FUNC_ENC) begin
            val0  = {2'b0, offset_enc(r_key_mode, enc_dw[5:0], k0)};
            val1  = {2'b0, offset_enc(r_key_mode, enc_dw[11:6], k1)};
            n_res = 2'd1;
            if (pe == 2'd2) begin
                n_res  = 2'd2;
                n_kp   = kp2;
                n_pend = '0;
                n_gp   = 2'd0;
            end else begin
                n_pend = enc_dw[11:6];
                n_gp   = pe + 2'd1;
                if (s_axis_tlast && (enc_dw[11:6] != 6'd0)) begin
                    n_res = 2'd2;
                end
            end
        end else begin
            n_gp = r_gp + 2'd1;
            if (r_gp == 2'd0) begin
                n_pend = dec_s;
                val0   = {2'b0, dec_s};
                if (s_axis_tlast && (dec_s != 6'd0)) begin
                    n_res = 2'd1;
                end
            end else begin
                n_pend = {2'b0, dec_dw[11:8]};
                val0   = dec_dw[7:0];
                val1   = {4'b0, dec_dw[11:8]};
                n_res  = 2'd1;
                if (s_axis_tlast && (dec_dw[11:8] != 4'd0)) begin
                    n_res = 2'd2;
                end
            end
        end

        if (s_axis_tlast) begin
            n_pend = '0;
            n_gp   = '0;
            n_kp   = '0;
        end
    end

    // result buffer, head at entry zero
    always_comb begin
        n_buf  = r_buf;
        base   = r_cnt;
        wr_idx = '0;
        if (pop) begin
            for (int i = 0; i < RES_DEPTH - 1; i++) begin
                n_buf[i] = r_buf[i + 1];
            end
            base = r_cnt - RES_CNT_W'(1);
        end
        n_cnt = base;
        if (push) begin
            wr_idx = base[1:0];
            if (n_res != 2'd0) begin
                n_buf[wr_idx] = '{data_out: val0, run_end: (n_res == 2'd1),
                                  message_end: (n_res == 2'd1) && s_axis_tlast};
            end
            if (n_res == 2'd2) begin
                n_buf[wr_idx + 2'd1] = '{data_out: val1, run_end: 1'b1,
                                         message_end: s_axis_tlast};
            end
            n_cnt = base + RES_CNT_W'(n_res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_mode   <= KEY_NONE;
            r_key_length <= 4'd1;
            r_key_chars  <= '0;
            r_pend       <= '0;
            r_gp         <= '0;
            r_kp         <= '0;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_KEY_MODE:   r_key_mode   <= i_cfg_data[1:0];
                    CFG_KEY_LENGTH: r_key_length <= i_cfg_data[3:0];
                    CFG_KEY_CHARS:  r_key_chars  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (push) begin
                r_pend <= n_pend;
                r_gp   <= n_gp;
                r_kp   <= n_kp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

`include "keyed_six_bit_packer_codec_assert.svh"

    `KSB_ASSERT_SAME(a_msg_end_is_run_end, m_axis_tvalid && m_axis_tlast, m_axis_tuser,
        "message end without run end")
    `KSB_ASSERT_NEXT(a_final_clears_state, push && s_axis_tlast,
        (r_pend == 6'd0) && (r_gp == 2'd0) && (r_kp == 3'd0),
        "final word left state behind")
    `KSB_ASSERT_NEXT(a_enc_third_byte_two,
        push && (s_axis_tuser == FUNC_ENC) && (r_gp == 2'd2),
        r_cnt == $past(r_cnt) + RES_CNT_W'(2) - RES_CNT_W'($past(pop)),
        "third byte did not give two symbols")
    `KSB_ASSERT_SAME(a_no_overfill, push,
        r_cnt + RES_CNT_W'(n_res) <= RES_CNT_W'(RES_DEPTH),
        "result buffer overfilled")

endmodule
